// ===== rtl/core/psrmv_pkg.sv =====
// Package: constants, types and state codes for the per-subcarrier mean/variance unit.
`default_nettype none
package psrmv_pkg;

    localparam int N_SUBCARRIERS = 56;
    localparam int SC_W          = 6;
    localparam int SC_IDX_W      = $clog2(N_SUBCARRIERS);
    localparam int AMP_W         = 8;
    localparam int FRAC_W        = 16;
    localparam int MEAN_W        = AMP_W + FRAC_W;
    localparam int M2_W          = 48;
    localparam int VAR_W         = 32;
    localparam int CNT_W         = 32;
    localparam int PROD_W        = 2 * MEAN_W;
    localparam int INC_W         = PROD_W - FRAC_W;
    localparam int DVD_W         = M2_W;
    localparam int DVS_W         = CNT_W;
    localparam int STEP_W        = 5;
    localparam int MEAN_STEPS    = MEAN_W / 2;
    localparam int VAR_STEPS     = DVD_W / 2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_MSTART,
        S_MWAIT,
        S_MUL,
        S_ACC,
        S_VSTART,
        S_VWAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic               start;
        logic [STEP_W-1:0]  steps;
        logic [DVD_W-1:0]   dividend;
        logic [DVS_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DVD_W-1:0]   quotient;
    } t_div_rsp;

endpackage
`default_nettype wire

// ===== rtl/core/psrmv_if.sv =====
// Valid/ready channel interfaces for the input sample and the result.
`default_nettype none
interface psrmv_in_if
    import psrmv_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [SC_W-1:0]    subcarrier;
    logic [AMP_W-1:0]   amplitude;
    logic               frame_start;

    modport source (output valid, output subcarrier, output amplitude, output frame_start,
                    input ready);
    modport sink   (input valid, input subcarrier, input amplitude, input frame_start,
                    output ready);
endinterface

interface psrmv_out_if
    import psrmv_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [SC_W-1:0]    subcarrier_echo;
    logic [MEAN_W-1:0]  mean_value;
    logic [VAR_W-1:0]   variance_value;
    logic [CNT_W-1:0]   frames_seen;

    modport source (output valid, output subcarrier_echo, output mean_value,
                    output variance_value, output frames_seen, input ready);
    modport sink   (input valid, input subcarrier_echo, input mean_value,
                    input variance_value, input frames_seen, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/psrmv_div.sv =====
// Restoring unsigned divider, two quotient bits per cycle.
`default_nettype none
module psrmv_div
    import psrmv_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DVD_W-1:0]  r_dvd;
    logic [DVS_W-1:0]  r_dvs;
    logic [DVS_W-1:0]  r_rem;

    logic [DVS_W:0]    w_s1;
    logic [DVS_W:0]    w_s2;
    logic [DVS_W:0]    w_r1;
    logic [DVS_W:0]    w_r2;
    logic              w_ge1;
    logic              w_ge2;

    always_comb begin
        w_s1  = {r_rem, r_dvd[DVD_W-1]};
        w_ge1 = w_s1 >= {1'b0, r_dvs};
        w_r1  = w_ge1 ? (w_s1 - {1'b0, r_dvs}) : w_s1;
        w_s2  = {w_r1[DVS_W-1:0], r_dvd[DVD_W-2]};
        w_ge2 = w_s2 >= {1'b0, r_dvs};
        w_r2  = w_ge2 ? (w_s2 - {1'b0, r_dvs}) : w_s2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-3:0], w_ge1, w_ge2};
            r_rem <= w_r2[DVS_W-1:0];
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_dvd;

endmodule
`default_nettype wire

// ===== rtl/core/per_subcarrier_running_mean_variance_unit.sv =====
// Top level: per-subcarrier running mean and sample variance, Welford update.
//
//   channel  dir  transaction
//   i_in     in   subcarrier, amplitude, frame_start
//   o_out    out  subcarrier_echo, mean_value, variance_value, frames_seen
//
// One sample in flight: the next is accepted only after the result is handed on. The
// mean step and, when the frame count exceeds one, M2/(n-1) run on the shared
// 2-bit-per-cycle divider; an out-of-range index skips both divisions.
// Synchronous reset clears the frame count and the per-entry valid bits; an entry
// not yet written reads as zero. A waiting result holds only the final hand-off.
`default_nettype none
module per_subcarrier_running_mean_variance_unit
    import psrmv_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    psrmv_in_if.sink   i_in,
    psrmv_out_if.source o_out
);

    logic [MEAN_W-1:0]        mem_mean [N_SUBCARRIERS];
    logic [M2_W-1:0]          mem_m2   [N_SUBCARRIERS];
    logic [N_SUBCARRIERS-1:0] r_vld;
    logic [MEAN_W-1:0]        r_mean_q;
    logic [M2_W-1:0]          r_m2_q;
    logic                     r_rd_vld;

    t_state            r_state,  n_state;
    logic [CNT_W-1:0]  r_n,      n_n;
    logic [SC_W-1:0]   r_sc,     n_sc;
    logic [AMP_W-1:0]  r_amp,    n_amp;
    logic              r_neg,    n_neg;
    logic [MEAN_W-1:0] r_d1,     n_d1;
    logic [MEAN_W-1:0] r_nm,     n_nm;
    logic [PROD_W-1:0] r_prod,   n_prod;
    logic [M2_W-1:0]   r_m2_new, n_m2_new;
    logic [VAR_W-1:0]  r_var,    n_var;
    logic              r_ovld,   n_ovld;
    logic [SC_W-1:0]   r_o_sc,   n_o_sc;
    logic [MEAN_W-1:0] r_o_mean, n_o_mean;
    logic [VAR_W-1:0]  r_o_var,  n_o_var;
    logic [CNT_W-1:0]  r_o_n,    n_o_n;

    logic              w_in_range;
    logic              w_we;
    logic [M2_W-1:0]   w_m2_wr;
    logic [MEAN_W-1:0] w_x;
    logic [MEAN_W-1:0] w_m;
    logic [M2_W-1:0]   w_m2;
    logic              w_ge;
    logic [MEAN_W-1:0] w_d1;
    logic [MEAN_W-1:0] w_d2;
    logic [MEAN_W-1:0] w_q;
    logic [DVS_W-1:0]  w_div_n;
    logic [M2_W:0]     w_sum;
    t_div_req          w_req;
    t_div_rsp          w_rsp;

    psrmv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_mean[r_sc[SC_IDX_W-1:0]] <= r_nm;
            mem_m2[r_sc[SC_IDX_W-1:0]]   <= w_m2_wr;
        end
        if (w_in_range) begin
            r_mean_q <= mem_mean[r_sc[SC_IDX_W-1:0]];
            r_m2_q   <= mem_m2[r_sc[SC_IDX_W-1:0]];
            r_rd_vld <= r_vld[r_sc[SC_IDX_W-1:0]];
        end
    end

    always_comb begin
        w_in_range = r_sc < SC_W'(N_SUBCARRIERS);
        w_x        = {r_amp, {FRAC_W{1'b0}}};
        w_m        = r_rd_vld ? r_mean_q : '0;
        w_m2       = r_rd_vld ? r_m2_q : '0;
        w_ge       = w_x >= w_m;
        w_d1       = w_ge ? (w_x - w_m) : (w_m - w_x);
        w_d2       = r_neg ? (r_nm - w_x) : (w_x - r_nm);
        w_q        = w_rsp.quotient[MEAN_W-1:0];
        w_div_n    = (r_n == '0) ? DVS_W'(1) : r_n;
        w_sum      = {1'b0, w_m2} + {{(M2_W + 1 - INC_W){1'b0}}, r_prod[PROD_W-1:FRAC_W]};
        w_m2_wr    = w_sum[M2_W] ? {M2_W{1'b1}} : w_sum[M2_W-1:0];
        w_we       = (r_state == S_ACC);
    end

    always_comb begin
        n_state  = r_state;
        n_n      = r_n;
        n_sc     = r_sc;
        n_amp    = r_amp;
        n_neg    = r_neg;
        n_d1     = r_d1;
        n_nm     = r_nm;
        n_prod   = r_prod;
        n_m2_new = r_m2_new;
        n_var    = r_var;
        n_ovld   = r_ovld & ~o_out.ready;
        n_o_sc   = r_o_sc;
        n_o_mean = r_o_mean;
        n_o_var  = r_o_var;
        n_o_n    = r_o_n;
        w_req    = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_sc  = i_in.subcarrier;
                    n_amp = i_in.amplitude;
                    if (i_in.frame_start && (r_n != {CNT_W{1'b1}})) begin
                        n_n = r_n + 1'b1;
                    end
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (w_in_range) begin
                    n_state = S_MSTART;
                end else begin
                    n_nm    = '0;
                    n_var   = '0;
                    n_state = S_OUT;
                end
            end
            S_MSTART: begin
                n_neg          = ~w_ge;
                n_d1           = w_d1;
                w_req.start    = 1'b1;
                w_req.steps    = STEP_W'(MEAN_STEPS);
                w_req.dividend = {w_d1, {(DVD_W - MEAN_W){1'b0}}};
                w_req.divisor  = w_div_n;
                n_state        = S_MWAIT;
            end
            S_MWAIT: begin
                if (w_rsp.done) begin
                    n_nm    = r_neg ? (w_m - w_q) : (w_m + w_q);
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = PROD_W'(r_d1) * PROD_W'(w_d2);
                n_state = S_ACC;
            end
            S_ACC: begin
                n_m2_new = w_m2_wr;
                if (r_n > CNT_W'(1)) begin
                    n_state = S_VSTART;
                end else begin
                    n_var   = '0;
                    n_state = S_OUT;
                end
            end
            S_VSTART: begin
                w_req.start    = 1'b1;
                w_req.steps    = STEP_W'(VAR_STEPS);
                w_req.dividend = r_m2_new;
                w_req.divisor  = r_n - 1'b1;
                n_state        = S_VWAIT;
            end
            S_VWAIT: begin
                if (w_rsp.done) begin
                    n_var   = (|w_rsp.quotient[DVD_W-1:VAR_W]) ? {VAR_W{1'b1}}
                                                               : w_rsp.quotient[VAR_W-1:0];
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ovld || o_out.ready) begin
                    n_ovld   = 1'b1;
                    n_o_sc   = r_sc;
                    n_o_mean = r_nm;
                    n_o_var  = r_var;
                    n_o_n    = r_n;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_n     <= '0;
            r_ovld  <= 1'b0;
            r_vld   <= '0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_ovld  <= n_ovld;
            if (w_we) begin
                r_vld[r_sc[SC_IDX_W-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sc     <= n_sc;
        r_amp    <= n_amp;
        r_neg    <= n_neg;
        r_d1     <= n_d1;
        r_nm     <= n_nm;
        r_prod   <= n_prod;
        r_m2_new <= n_m2_new;
        r_var    <= n_var;
        r_o_sc   <= n_o_sc;
        r_o_mean <= n_o_mean;
        r_o_var  <= n_o_var;
        r_o_n    <= n_o_n;
    end

    assign i_in.ready            = (r_state == S_IDLE);
    assign o_out.valid           = r_ovld;
    assign o_out.subcarrier_echo = r_o_sc;
    assign o_out.mean_value      = r_o_mean;
    assign o_out.variance_value  = r_o_var;
    assign o_out.frames_seen     = r_o_n;

endmodule
`default_nettype wire

// ===== rtl/core/psrmv_chk.sv =====
// Port-level checker for the mean/variance unit, bound to the top level.
`default_nettype none
module psrmv_chk
    import psrmv_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              i_in_ready,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire logic [SC_W-1:0]   i_out_sc,
    input wire logic [MEAN_W-1:0] i_out_mean,
    input wire logic [VAR_W-1:0]  i_out_var,
    input wire logic [CNT_W-1:0]  i_out_frames
);

    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("second transaction taken while one is in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_mean)
                                          && $stable(i_out_var) && $stable(i_out_frames)))
        else $error("stalled result changed");

    a_var_needs_frames: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_frames <= CNT_W'(1))) |-> (i_out_var == '0))
        else $error("variance nonzero with frame count at most one");

    a_out_of_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_sc >= SC_W'(N_SUBCARRIERS)))
            |-> ((i_out_mean == '0) && (i_out_var == '0)))
        else $error("out-of-range subcarrier returned statistics");

endmodule

bind per_subcarrier_running_mean_variance_unit psrmv_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_sc     (o_out.subcarrier_echo),
    .i_out_mean   (o_out.mean_value),
    .i_out_var    (o_out.variance_value),
    .i_out_frames (o_out.frames_seen)
);
`default_nettype wire
